>>> src/zero_suppressed_sequence_decoder_core_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst in the using module.
`ifndef ZERO_SUPPRESSED_SEQUENCE_DECODER_CORE_MACROS_SVH
`define ZERO_SUPPRESSED_SEQUENCE_DECODER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZSSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zssd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ZSSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zssd: next-cycle check failed");

`endif

>>> src/zssd_pkg.sv
package zssd_pkg;

  // Record index cap and width of the running ADC byte offset
  localparam int MaxRecords = 256;
  localparam int OffsetBits = 24;
  localparam int RecCap     = MaxRecords - 1;

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Saturation limits
  localparam logic [9:0] LenMax = 10'd1023;
  localparam logic [8:0] PadMax = 9'd256;
  localparam logic [7:0] CntMax = 8'd255;
  localparam logic [7:0] PadEnd = 8'd255;
  localparam logic [OffsetBits-1:0] OffMax = {OffsetBits{1'b1}};

  // Signed last-bin value meaning "no run yet on this pad"
  localparam logic signed [10:0] LastBinNone = -11'sd2;

  typedef enum logic [1:0] {
    ITEM_HEADER,
    ITEM_BANK_END,
    ITEM_SEQUENCE
  } item_kind_t;

  typedef enum logic [2:0] {
    STATUS_NEW       = 3'd0,
    STATUS_EXTEND    = 3'd1,
    STATUS_BANK_END  = 3'd2,
    STATUS_NO_HEADER = 3'd3,
    STATUS_BACKWARD  = 3'd4
  } status_t;

  // One classified descriptor word
  typedef struct packed {
    item_kind_t  kind;
    logic        bank_start;
    logic [1:0]  row;
    logic [7:0]  pad;
    logic [8:0]  start;
    logic [4:0]  len;
    logic        last_of_pad;
  } item_t;

endpackage

>>> src/zssd_fifo.sv
`include "zero_suppressed_sequence_decoder_core_macros.svh"

module zssd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  zssd_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output zssd_pkg::item_t head
);

  zssd_pkg::item_t                      entries [zssd_pkg::QueueDepth];
  logic [zssd_pkg::QueuePtrW-1:0]       wr_ptr;
  logic [zssd_pkg::QueuePtrW-1:0]       rd_ptr;
  logic [zssd_pkg::QueueCntW-1:0]       count;

  assign full      = (count == zssd_pkg::QueueCntW'(zssd_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == zssd_pkg::QueuePtrW'(zssd_pkg::QueueDepth - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == zssd_pkg::QueuePtrW'(zssd_pkg::QueueDepth - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `ZSSD_ASSERT_SAME(a_fifo_pop_nonempty, pop, count != '0)
  `ZSSD_ASSERT_SAME(a_fifo_count_range, 1'b1, count <= zssd_pkg::QueueCntW'(zssd_pkg::QueueDepth))
  `ZSSD_ASSERT_NEXT(a_fifo_count_up, push && !pop, count == $past(count) + 1'b1)

endmodule

>>> src/zssd_front.sv
module zssd_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [15:0]     desc_word,
  input  logic            bank_start,
  input  logic            queue_full,
  output logic            push,
  output zssd_pkg::item_t item
);

  // (x / 6) by reciprocal: x * 43 >> 8 is exact for x below 128
  localparam logic [12:0] Div6Mul   = 13'd43;
  localparam int          Div6Shift = 8;

  logic [6:0]  raw_row;
  logic [6:0]  row_m1;
  logic [12:0] div_prod;
  logic        row_odd;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Padrow mapping: raw 0 -> 1, else ((raw-1)/6)%2 + 1
  assign raw_row  = desc_word[14:8];
  assign row_m1   = raw_row - 7'd1;
  assign div_prod = 13'(row_m1) * Div6Mul;
  assign row_odd  = div_prod[Div6Shift];

  // Classify the word and split out its fields
  always_comb begin
    item.bank_start  = bank_start;
    item.row         = (raw_row == '0) ? 2'd1 : {1'b0, row_odd} + 2'd1;
    item.pad         = desc_word[7:0];
    item.start       = desc_word[14:6];
    item.len         = desc_word[4:0];
    item.last_of_pad = desc_word[5];
    if (!desc_word[15]) begin
      item.kind = zssd_pkg::ITEM_SEQUENCE;
    end else if (desc_word[7:0] == zssd_pkg::PadEnd) begin
      item.kind = zssd_pkg::ITEM_BANK_END;
    end else begin
      item.kind = zssd_pkg::ITEM_HEADER;
    end
  end

endmodule

>>> src/zssd_back.sv
`include "zero_suppressed_sequence_decoder_core_macros.svh"

module zssd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  zssd_pkg::item_t item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [2:0]      status,
  output logic [1:0]      row_sel,
  output logic [8:0]      pad_num,
  output logic [7:0]      record_index,
  output logic [8:0]      start_bin,
  output logic [9:0]      run_length,
  output logic [23:0]     adc_offset
);

  localparam int OB = zssd_pkg::OffsetBits;

  // Decoder state
  logic                    header_seen, header_seen_next;
  logic                    halted, halted_next;
  logic [1:0]              cur_row, cur_row_next;
  logic [8:0]              cur_pad, cur_pad_next;
  logic [8:0]              prev_start, prev_start_next;
  logic signed [10:0]      last_bin, last_bin_next;
  logic [7:0]              record_count, record_count_next;
  logic [8:0]              rec_start, rec_start_next;
  logic [9:0]              rec_length, rec_length_next;
  logic [23:0]             rec_offset, rec_offset_next;
  logic [OB-1:0]           byte_offset, byte_offset_next;

  // State as seen after an optional bank start
  logic                    b_header_seen, b_halted;
  logic [1:0]              b_row;
  logic [8:0]              b_pad, b_prev;
  logic signed [10:0]      b_last;
  logic [7:0]              b_count;
  logic [8:0]              b_rec_start;
  logic [9:0]              b_rec_length;
  logic [23:0]             b_rec_offset;
  logic [OB-1:0]           b_offset;

  // Result of this beat
  logic                    res_valid;
  zssd_pkg::status_t       res_status;
  logic [1:0]              res_row;
  logic [8:0]              res_pad;
  logic [7:0]              res_index;
  logic [8:0]              res_start;
  logic [9:0]              res_length;
  logic [23:0]             res_offset;

  // Arithmetic helpers
  logic signed [10:0]      start_s, last_p1, run_end;
  logic [10:0]             len_sum;
  logic [OB:0]             off_sum;
  logic [31:0]             off_wide;
  logic [7:0]              count_m1;
  logic                    is_new;

  // Held result carries an error status
  logic                    out_err;

  assign pop = item_valid && (!out_valid || !out_stall);

  assign start_s  = $signed({2'b00, item.start});
  assign last_p1  = b_last + 11'sd1;
  assign run_end  = start_s + $signed({6'b000000, item.len}) - 11'sd1;
  assign is_new   = start_s > last_p1;
  assign len_sum  = {1'b0, b_rec_length} + 11'(item.len);
  assign off_sum  = {1'b0, b_offset} + (OB+1)'(item.len);
  assign off_wide = 32'(b_offset);

  // Bank start brings the state back to its reset values
  always_comb begin
    if (item.bank_start) begin
      b_header_seen = 1'b0;
      b_halted      = 1'b0;
      b_row         = 2'd1;
      b_pad         = '0;
      b_prev        = '0;
      b_last        = zssd_pkg::LastBinNone;
      b_count       = '0;
      b_rec_start   = '0;
      b_rec_length  = '0;
      b_rec_offset  = '0;
      b_offset      = '0;
    end else begin
      b_header_seen = header_seen;
      b_halted      = halted;
      b_row         = cur_row;
      b_pad         = cur_pad;
      b_prev        = prev_start;
      b_last        = last_bin;
      b_count       = record_count;
      b_rec_start   = rec_start;
      b_rec_length  = rec_length;
      b_rec_offset  = rec_offset;
      b_offset      = byte_offset;
    end
  end

  // Execute one classified word
  always_comb begin
    header_seen_next  = b_header_seen;
    halted_next       = b_halted;
    cur_row_next      = b_row;
    cur_pad_next      = b_pad;
    prev_start_next   = b_prev;
    last_bin_next     = b_last;
    record_count_next = b_count;
    rec_start_next    = b_rec_start;
    rec_length_next   = b_rec_length;
    rec_offset_next   = b_rec_offset;
    byte_offset_next  = b_offset;
    count_m1          = '0;
    res_valid         = 1'b0;
    res_status        = zssd_pkg::STATUS_NEW;
    res_row           = b_row;
    res_pad           = b_pad;
    res_index         = '0;
    res_start         = '0;
    res_length        = '0;
    res_offset        = off_wide[23:0];

    if (!b_halted) begin
      unique case (item.kind)
        zssd_pkg::ITEM_HEADER: begin
          cur_row_next      = item.row;
          cur_pad_next      = {1'b0, item.pad};
          header_seen_next  = 1'b1;
          record_count_next = '0;
          prev_start_next   = '0;
          last_bin_next     = zssd_pkg::LastBinNone;
        end
        zssd_pkg::ITEM_BANK_END: begin
          cur_row_next = item.row;
          cur_pad_next = {1'b0, item.pad};
          halted_next  = 1'b1;
          res_valid    = 1'b1;
          res_status   = zssd_pkg::STATUS_BANK_END;
          res_row      = item.row;
          res_pad      = {1'b0, item.pad};
        end
        zssd_pkg::ITEM_SEQUENCE: begin
          res_valid = 1'b1;
          if (!b_header_seen) begin
            halted_next = 1'b1;
            res_status  = zssd_pkg::STATUS_NO_HEADER;
          end else if (item.start < b_prev) begin
            halted_next = 1'b1;
            res_status  = zssd_pkg::STATUS_BACKWARD;
          end else begin
            if (is_new) begin
              res_status = zssd_pkg::STATUS_NEW;
              if (b_count < zssd_pkg::CntMax) begin
                record_count_next = b_count + 8'd1;
              end
              rec_start_next  = item.start;
              rec_length_next = 10'(item.len);
              rec_offset_next = off_wide[23:0];
            end else begin
              res_status = zssd_pkg::STATUS_EXTEND;
              if (b_count == '0) begin
                record_count_next = 8'd1;
              end
              rec_length_next = len_sum[10] ? zssd_pkg::LenMax : len_sum[9:0];
            end
            // Index within the pad, capped
            count_m1 = record_count_next - 8'd1;
            if ({2'b00, count_m1} > 10'(zssd_pkg::RecCap)) begin
              res_index = 8'(zssd_pkg::RecCap);
            end else begin
              res_index = count_m1;
            end
            res_start  = rec_start_next;
            res_length = rec_length_next;
            res_offset = rec_offset_next;

            byte_offset_next = off_sum[OB] ? zssd_pkg::OffMax : off_sum[OB-1:0];
            last_bin_next    = run_end;
            prev_start_next  = item.start;
            // Last run on this pad: step to the next pad
            if (item.last_of_pad) begin
              if (b_pad < zssd_pkg::PadMax) begin
                cur_pad_next = b_pad + 9'd1;
              end
              record_count_next = '0;
              prev_start_next   = '0;
              last_bin_next     = zssd_pkg::LastBinNone;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers, advanced once per popped beat
  always_ff @(posedge clk) begin
    if (rst) begin
      header_seen  <= 1'b0;
      halted       <= 1'b0;
      cur_row      <= 2'd1;
      cur_pad      <= '0;
      prev_start   <= '0;
      last_bin     <= zssd_pkg::LastBinNone;
      record_count <= '0;
      rec_start    <= '0;
      rec_length   <= '0;
      rec_offset   <= '0;
      byte_offset  <= '0;
    end else if (pop) begin
      header_seen  <= header_seen_next;
      halted       <= halted_next;
      cur_row      <= cur_row_next;
      cur_pad      <= cur_pad_next;
      prev_start   <= prev_start_next;
      last_bin     <= last_bin_next;
      record_count <= record_count_next;
      rec_start    <= rec_start_next;
      rec_length   <= rec_length_next;
      rec_offset   <= rec_offset_next;
      byte_offset  <= byte_offset_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      status       <= res_status;
      row_sel      <= res_row;
      pad_num      <= res_pad;
      record_index <= res_index;
      start_bin    <= res_start;
      run_length   <= res_length;
      adc_offset   <= res_offset;
    end
  end

  assign out_err = (status == zssd_pkg::STATUS_BANK_END) ||
                   (status == zssd_pkg::STATUS_NO_HEADER) ||
                   (status == zssd_pkg::STATUS_BACKWARD);

  `ZSSD_ASSERT_SAME(a_err_implies_halted, out_valid && out_err, halted)
  `ZSSD_ASSERT_NEXT(a_halted_silent, pop && halted && !item.bank_start, !out_valid)
  `ZSSD_ASSERT_SAME(a_no_header_no_count, !header_seen, record_count == '0)

endmodule

>>> src/zero_suppressed_sequence_decoder_core.sv
// Channel  Valid      Stall      Payload
// input    in_valid   in_stall   desc_word, bank_start
// output   out_valid  out_stall  status, row_sel, pad_num, record_index,
//                                start_bin, run_length, adc_offset
//
// One descriptor word per cycle sustained while out_stall is low; an input
// beat passes through the queue entry, then the execute stage that loads the
// output register. The execute stage updates all decoder state together.
// Synchronous active-high rst clears the queue, the output valid flag and all
// decoder state. Output stall holds the result and backs up the two-entry
// queue; input stall rises only when that queue is full.
module zero_suppressed_sequence_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] desc_word,
  input  logic        bank_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [1:0]  row_sel,
  output logic [8:0]  pad_num,
  output logic [7:0]  record_index,
  output logic [8:0]  start_bin,
  output logic [9:0]  run_length,
  output logic [23:0] adc_offset
);

  logic            push;
  logic            pop;
  logic            queue_full;
  logic            queue_valid;
  zssd_pkg::item_t front_item;
  zssd_pkg::item_t queue_head;

  // Decode and classify incoming words
  zssd_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .desc_word  (desc_word),
    .bank_start (bank_start),
    .queue_full (queue_full),
    .push       (push),
    .item       (front_item)
  );

  // Short queue between front and back
  zssd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_valid),
    .head      (queue_head)
  );

  // Execute words and hold the result
  zssd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (queue_valid),
    .item         (queue_head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .row_sel      (row_sel),
    .pad_num      (pad_num),
    .record_index (record_index),
    .start_bin    (start_bin),
    .run_length   (run_length),
    .adc_offset   (adc_offset)
  );

endmodule
